// ===== src/rfb_pkg.sv =====
// shared types and constants for the ring fifo with bursts
package rfb_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;
  localparam int DATA_W        = 16;
  localparam int COUNT_W       = 7;
  localparam int LEVEL_OUT_W   = 8;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_BWR  = 2'd2,
    KIND_BRD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [DATA_W-1:0]   data;
    logic                first;
    logic [COUNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic                   ok;
    logic [DATA_W-1:0]      word_out;
    logic                   word_valid;
    logic                   last;
    logic [LEVEL_OUT_W-1:0] level;
    logic                   empty_res;
    logic                   full_res;
  } out_item_t;

endpackage

// ===== src/rfb_ram.sv =====
// word storage: one write port, one read port with registered read data
module rfb_ram import rfb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rfb_ctrl.sv =====
// pointer, level and burst control with the registered result stage
module rfb_ctrl import rfb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [DATA_W-1:0] wdata,
  output logic              re,
  output logic [AW-1:0]     raddr,
  input  logic [DATA_W-1:0] rdata
);

  localparam int CW = (AW > COUNT_W) ? AW + 1 : COUNT_W + 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LVL_FULL = AW'(DEPTH - 1);
  localparam logic [CW-1:0] MB_C     = CW'(MAX_BURST);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rp_r, rp_nxt;
  logic [AW-1:0]      lvl_r, lvl_nxt;
  logic [COUNT_W-1:0] bw_left_r, bw_left_nxt;
  logic               bw_acc_r, bw_acc_nxt;
  logic [COUNT_W-1:0] rd_left_r, rd_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          meta_r, meta_nxt;

  logic               full;
  logic [CW-1:0]      cnt_c;
  logic [CW-1:0]      lvl_c;
  logic [CW-1:0]      space_c;
  logic [COUNT_W-1:0] eff_left;
  logic               eff_acc;
  logic [AW+LEVEL_OUT_W-1:0] lvl_ext;

  assign full    = (lvl_r == LVL_FULL);
  assign cnt_c   = CW'(in_item.count);
  assign lvl_c   = CW'(lvl_r);
  assign space_c = CW'(LVL_FULL) - lvl_c;
  assign lvl_ext = {{LEVEL_OUT_W{1'b0}}, lvl_nxt};

  assign waddr = wp_r;
  assign raddr = rp_r;
  assign wdata = in_item.data;

  // next-state logic: one item per cycle while not busy, burst reads stream one word per cycle
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    lvl_nxt       = lvl_r;
    bw_left_nxt   = bw_left_r;
    bw_acc_nxt    = bw_acc_r;
    rd_left_nxt   = rd_left_r;
    out_valid_nxt = 1'b0;
    meta_nxt      = meta_r;
    we            = 1'b0;
    re            = 1'b0;
    eff_left      = bw_left_r;
    eff_acc       = bw_acc_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt       = 1'b1;
          meta_nxt.ok         = 1'b0;
          meta_nxt.word_out   = '0;
          meta_nxt.word_valid = 1'b0;
          meta_nxt.last       = 1'b1;
          case (in_item.kind)
            KIND_PUSH: begin
              bw_left_nxt = '0;
              bw_acc_nxt  = 1'b0;
              if (!full) begin
                we          = 1'b1;
                wp_nxt      = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
                lvl_nxt     = lvl_r + 1'b1;
                meta_nxt.ok = 1'b1;
              end
            end
            KIND_POP: begin
              bw_left_nxt = '0;
              bw_acc_nxt  = 1'b0;
              if (lvl_r != '0) begin
                re                  = 1'b1;
                rp_nxt              = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
                lvl_nxt             = lvl_r - 1'b1;
                meta_nxt.ok         = 1'b1;
                meta_nxt.word_valid = 1'b1;
              end
            end
            KIND_BWR: begin
              // a first element opens a new burst and checks its length against MAX_BURST and its room
              if (in_item.first) begin
                eff_left = in_item.count;
                eff_acc  = (cnt_c <= MB_C) && (cnt_c <= space_c);
              end
              if (in_item.first && in_item.count == '0) begin
                meta_nxt.ok = eff_acc;
                bw_left_nxt = '0;
                bw_acc_nxt  = 1'b0;
              end else if (eff_left != '0) begin
                if (eff_acc && !full) begin
                  we          = 1'b1;
                  wp_nxt      = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
                  lvl_nxt     = lvl_r + 1'b1;
                  meta_nxt.ok = 1'b1;
                end
                bw_left_nxt = eff_left - 1'b1;
                bw_acc_nxt  = (eff_left == COUNT_W'(1)) ? 1'b0 : eff_acc;
              end else begin
                bw_left_nxt = eff_left;
                bw_acc_nxt  = eff_acc;
              end
            end
            KIND_BRD: begin
              bw_left_nxt = '0;
              bw_acc_nxt  = 1'b0;
              if ((cnt_c > MB_C) || (cnt_c > lvl_c)) begin
                meta_nxt.ok = 1'b0;
              end else if (in_item.count == '0) begin
                meta_nxt.ok = 1'b1;
              end else begin
                re                  = 1'b1;
                rp_nxt              = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
                lvl_nxt             = lvl_r - 1'b1;
                meta_nxt.ok         = 1'b1;
                meta_nxt.word_valid = 1'b1;
                meta_nxt.last       = (in_item.count == COUNT_W'(1));
                rd_left_nxt         = in_item.count - 1'b1;
                state_nxt = (in_item.count == COUNT_W'(1)) ? ST_IDLE : ST_BURST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BURST: begin
        // one more word of a granted burst read
        re                  = 1'b1;
        rp_nxt              = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
        lvl_nxt             = lvl_r - 1'b1;
        out_valid_nxt       = 1'b1;
        meta_nxt.ok         = 1'b1;
        meta_nxt.word_out   = '0;
        meta_nxt.word_valid = 1'b1;
        meta_nxt.last       = (rd_left_r == COUNT_W'(1));
        rd_left_nxt         = rd_left_r - 1'b1;
        if (rd_left_r == COUNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // status after the step
    meta_nxt.level     = lvl_ext[LEVEL_OUT_W-1:0];
    meta_nxt.empty_res = (lvl_nxt == '0);
    meta_nxt.full_res  = (lvl_nxt == LVL_FULL);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      lvl_r       <= '0;
      bw_left_r   <= '0;
      bw_acc_r    <= 1'b0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      lvl_r       <= lvl_nxt;
      bw_left_r   <= bw_left_nxt;
      bw_acc_r    <= bw_acc_nxt;
      rd_left_r   <= rd_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  // popped word comes straight from the memory read register
  always_comb begin
    out_item          = meta_r;
    out_item.word_out = meta_r.word_valid ? rdata : '0;
  end

  assign out_valid = out_valid_r;
  assign busy      = (state_r == ST_BURST);

endmodule

// ===== src/ring_fifo_with_bursts.sv =====
// Ring FIFO of 16-bit words with single and burst push/pop, top level.
// An item is taken whenever start is high and busy is low, one item per clock. Every
// item gives its first result in the cycle after it is taken, on out_valid for exactly one
// cycle; the receiver cannot hold results off, so it must take each one as it comes. A
// granted burst read of n words streams its n results back to back and holds busy high
// until its last word is read, since the single memory read port delivers one word per
// cycle. The ring holds DEPTH-1 words; storage needs no clearing after reset.
module ring_fifo_with_bursts import rfb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  // control and result stage
  rfb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // word storage
  rfb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
